[src/bsip_pkg.sv]
// Shared definitions for the sorted-table insert-position search block.
// Holds field widths, parameter defaults, request codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bsip_pkg;

	// Parameter defaults
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int SIZE_W  = 11;
	localparam int INDEX_W = 10;
	localparam int POS_W   = 11;

	// Request codes
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic write;     // store the accepted value into the table
		logic start;     // latch target, open the full range
		logic issue;     // latch midpoint, read the table there
		logic step;      // compare read data, narrow the range
		logic load_out;  // move the answer into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic range_empty;  // low has reached one past high
		logic hit;          // probed entry equals the target
		logic out_free;     // output register can take a beat
	} sts_t;

endpackage

[src/bsip_item_if.sv]
// Request channel: valid/ready handshake carrying one request beat.
// Depends on bsip_pkg for the default value width and field widths.
`timescale 1ns / 1ps

interface bsip_item_if #(
	parameter int VALUE_WIDTH = bsip_pkg::VALUE_WIDTH_DEF
) ();
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic [bsip_pkg::INDEX_W-1:0]     entry_index;
	logic signed [VALUE_WIDTH-1:0]    item_value;

	modport source (output valid, output req_type, output entry_index, output item_value,
		input ready);
	modport sink (input valid, input req_type, input entry_index, input item_value,
		output ready);
endinterface

[src/bsip_result_if.sv]
// Result channel: valid/ready handshake carrying one search answer beat.
// Depends on bsip_pkg for the position width.
`timescale 1ns / 1ps

interface bsip_result_if ();
	logic                        valid;
	logic                        ready;
	logic [bsip_pkg::POS_W-1:0]  position;
	logic                        found;

	modport source (output valid, output position, output found, input ready);
	modport sink (input valid, input position, input found, output ready);
endinterface

[src/bsip_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bsip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/bsip_datapath.sv]
// Datapath: table memory, size register, search range, compare and output register.
// Depends on bsip_pkg and bsip_ram; driven by bsip_ctrl through cmd_t/sts_t.
`timescale 1ns / 1ps

module bsip_datapath #(
	parameter int TABLE_DEPTH = bsip_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = bsip_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsip_pkg::cmd_t                cmd,
	output bsip_pkg::sts_t                sts,
	input  logic                          cfg_wr_en,
	input  logic [bsip_pkg::SIZE_W-1:0]   cfg_wr_data,
	input  logic [bsip_pkg::INDEX_W-1:0]  entry_index,
	input  logic [VALUE_WIDTH-1:0]        item_value,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bsip_pkg::POS_W-1:0]    out_position,
	output logic                          out_found
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (CW > bsip_pkg::SIZE_W) ? CW : bsip_pkg::SIZE_W;
	localparam int XW = (CW > bsip_pkg::INDEX_W) ? CW : bsip_pkg::INDEX_W;

	logic [bsip_pkg::SIZE_W-1:0] table_size_q;
	logic [VALUE_WIDTH-1:0]      target_q;
	logic [CW-1:0]               lo_q;
	logic [CW-1:0]               hip1_q;
	logic [CW-1:0]               mid_q;
	logic                        found_q;
	logic                        out_valid_q;
	logic [bsip_pkg::POS_W-1:0]  out_pos_q;
	logic                        out_found_q;

	logic [SW-1:0]          size_ext;
	logic [CW-1:0]          entries;
	logic [XW-1:0]          idx_ext;
	logic                   wr_ok;
	logic [CW-1:0]          span;
	logic [CW-1:0]          mid;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   probe_lt;

	// Clamp the size register to the table depth
	assign size_ext = SW'(table_size_q);
	assign entries  = (size_ext > SW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(size_ext);

	// Drop writes beyond the table
	assign idx_ext = XW'(entry_index);
	assign wr_ok   = idx_ext < XW'(TABLE_DEPTH);

	// Midpoint of the closed range [lo, hip1 - 1]
	assign span = hip1_q - lo_q;
	assign mid  = lo_q + ((span - CW'(1)) >> 1);

	bsip_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd.write && wr_ok),
		.wr_addr (IW'(entry_index)),
		.wr_data (item_value),
		.rd_en   (cmd.issue),
		.rd_addr (IW'(mid)),
		.rd_data (rd_data)
	);

	// Signed compare of the probed entry against the target
	assign probe_lt = $signed(rd_data) < $signed(target_q);

	assign sts.range_empty = lo_q >= hip1_q;
	assign sts.hit         = rd_data == target_q;
	assign sts.out_free    = !out_valid_q || out_ready;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
		end else if (cfg_wr_en) begin
			table_size_q <= cfg_wr_data;
		end
	end

	// Search range and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= '0;
			hip1_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.start) begin
			lo_q    <= '0;
			hip1_q  <= entries;
			found_q <= 1'b0;
		end else if (cmd.step) begin
			priority if (sts.hit) begin
				found_q <= 1'b1;
			end else if (probe_lt) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hip1_q <= mid_q;
			end
		end
	end

	// Target and midpoint hold for the whole probe
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			target_q <= item_value;
		end
		if (cmd.issue) begin
			mid_q <= mid;
		end
	end

	// Output register: hold the beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pos_q   <= bsip_pkg::POS_W'(found_q ? mid_q : hip1_q);
			out_found_q <= found_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_pos_q;
	assign out_found    = out_found_q;

endmodule

[src/bsip_ctrl.sv]
// Controller: sequences one request at a time through probe and compare steps.
// Depends on bsip_pkg; drives bsip_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module bsip_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_req_type,
	output logic           in_ready,
	input  bsip_pkg::sts_t sts,
	output bsip_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Commands decoded from state and status
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.write = in_valid && (in_req_type == bsip_pkg::REQ_WRITE);
				cmd.start = in_valid && (in_req_type == bsip_pkg::REQ_SEARCH);
			end
			ST_PROBE: begin
				cmd.issue = !sts.range_empty;
			end
			ST_COMPARE: begin
				cmd.step = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					state_q <= sts.range_empty ? ST_FINISH : ST_COMPARE;
				end
				ST_COMPARE: begin
					state_q <= sts.hit ? ST_FINISH : ST_PROBE;
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/binary_search_insert_position.sv]
// Top level of the sorted-table insert-position search block.
// Depends on bsip_pkg, bsip_item_if, bsip_result_if, bsip_ctrl and bsip_datapath.
`timescale 1ns / 1ps

// Usage:
//   item   : request beats. req_type write stores item_value at entry_index
//            (slots at or beyond TABLE_DEPTH are dropped) and gives no result.
//            req_type search looks up item_value in the first table_size
//            entries, which software keeps in ascending signed order.
//   result : one beat per search: position of an equal entry, or the
//            insertion point, with found set on a match.
//   cfg_wr_en / cfg_wr_data : write table_size while the block is idle;
//            values above TABLE_DEPTH act as TABLE_DEPTH.
// Timing: a search runs P probes, each a table address out, a registered
//   memory read, then a compare; P is at most clog2(table_size + 1): eleven
//   for 1024 entries. A match ends the search early. The next request is
//   taken in the cycle after the answer is loaded into the output register.
//   The block takes one search at a time through the single read port of
//   the table memory.
// Reset: clears table_size, the search range and the output valid; the
//   table contents stay undefined until written. No clearing pass.
// Stall: the output register holds a beat until taken; the next request is
//   accepted meanwhile, and a search that finishes waits for it to drain.
module binary_search_insert_position #(
	parameter int TABLE_DEPTH = bsip_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = bsip_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bsip_pkg::SIZE_W-1:0] cfg_wr_data,
	bsip_item_if.sink                   item,
	bsip_result_if.source               result
);

	bsip_pkg::cmd_t cmd;
	bsip_pkg::sts_t sts;

	bsip_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (item.valid),
		.in_req_type (item.req_type),
		.in_ready    (item.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	bsip_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.entry_index  (item.entry_index),
		.item_value   (item.item_value),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_position (result.position),
		.out_found    (result.found)
	);

`ifndef SYNTHESIS
	// An answer is only loaded when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("answer loaded over an untaken result beat");

	// A table read is only issued on a non-empty range
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !sts.range_empty)
		else $error("probe issued on an empty range");

	// A loaded answer shows on the result channel next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> result.valid)
		else $error("loaded answer missing from result channel");

	// No new search starts while a previous one is still probing
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !item.ready)
		else $error("request accepted during a search");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for binary_search_insert_position: loads sorted tables,
// searches them, and checks every answer against a built-in search predictor.
// Depends on bsip_pkg, bsip_item_if, bsip_result_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int     VALUE_W        = bsip_pkg::VALUE_WIDTH_DEF;
	localparam int     TABLE_SLOTS    = bsip_pkg::TABLE_DEPTH_DEF;
	localparam int     ITEM_GOAL      = 1950;
	localparam int     IDLE_GUARD     = 32;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam longint VAL_MIN        = -64'sd2147483648;
	localparam longint VAL_MAX        = 64'sd2147483647;

	typedef struct packed {
		logic [bsip_pkg::POS_W-1:0] position;
		logic                       found;
	} answer_t;

	// Table image, size register and search predictor; queue of pending answers
	class search_scoreboard;
		logic signed [VALUE_W-1:0]    table_vals [TABLE_SLOTS];
		logic [bsip_pkg::SIZE_W-1:0]  size_reg;
		int                           last_low;
		int                           last_high;
		answer_t                      answer_q [$];
		int                           errors;

		function new();
			size_reg  = '0;
			last_low  = 0;
			last_high = 0;
			errors    = 0;
		endfunction

		function void set_size(logic [bsip_pkg::SIZE_W-1:0] v);
			size_reg = v;
		endfunction

		function int pending();
			return answer_q.size();
		endfunction

		// Apply an accepted request beat; predict the answer of a search
		function void note_item(logic req, logic [bsip_pkg::INDEX_W-1:0] idx,
				logic signed [VALUE_W-1:0] val);
			int      lo;
			int      hi;
			int      mid;
			int      n_eff;
			int      ins;
			logic    hit;
			answer_t ans;
			if (req == bsip_pkg::REQ_WRITE) begin
				table_vals[idx] = val;
				return;
			end
			n_eff = (size_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(size_reg);
			lo  = 0;
			hi  = n_eff - 1;
			mid = 0;
			hit = 1'b0;
			while (!hit && lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (table_vals[mid] < val)
					lo = mid + 1;
				else if (table_vals[mid] > val)
					hi = mid - 1;
				else
					hit = 1'b1;
			end
			ins = hi + 1;
			ans.position = hit ? mid[bsip_pkg::POS_W-1:0] : ins[bsip_pkg::POS_W-1:0];
			ans.found    = hit;
			last_low  = lo;
			last_high = hi + 1;
			answer_q.push_back(ans);
		endfunction

		// Compare an accepted result beat with the oldest pending answer
		function void check_result(logic [bsip_pkg::POS_W-1:0] pos, logic fnd);
			answer_t want;
			if (answer_q.size() == 0) begin
				errors++;
				$display("%0t ERROR result with none pending: position %0d found %0d",
					$time, pos, fnd);
				return;
			end
			want = answer_q.pop_front();
			if (pos !== want.position) begin
				errors++;
				$display("%0t ERROR position expected %0d actual %0d",
					$time, want.position, pos);
			end
			if (fnd !== want.found) begin
				errors++;
				$display("%0t ERROR found expected %0d actual %0d",
					$time, want.found, fnd);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [bsip_pkg::SIZE_W-1:0] cfg_wr_data;

	bsip_item_if   item_bus ();
	bsip_result_if res_bus ();

	binary_search_insert_position i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_bus),
		.result      (res_bus)
	);

	search_scoreboard sb;
	int               items_sent;
	int               burst_left;
	int               idle_cycles = 0;
	int               stall_left  = 0;
	int               rx_mode     = 0;
	int               rx_cycle    = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Send one request beat; open a new burst with a random gap when the old one runs out
	task automatic send_item(input logic req, input logic [bsip_pkg::INDEX_W-1:0] idx,
			input logic signed [VALUE_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				item_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_bus.valid       <= 1'b1;
		item_bus.req_type    <= req;
		item_bus.entry_index <= idx;
		item_bus.item_value  <= val;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		sb.note_item(req, idx, val);
		items_sent++;
	endtask

	// Hold off until every answer has arrived, then let the block settle
	task automatic drain();
		item_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic set_table_size(input logic [bsip_pkg::SIZE_W-1:0] v);
		cfg_wr_data <= v;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_size(v);
	endtask

	// Write slots 0..n-1 in ascending order with one of several value spreads
	task automatic fill_sorted(input int n);
		longint      cur;
		longint      span;
		int unsigned step_cap;
		int          sv;
		sv = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				cur = sv;
				step_cap = 2;
			end
			1: begin
				cur = sv / 2;
				step_cap = 1000;
			end
			2: begin
				cur  = VAL_MIN + $urandom_range(0, 1000);
				span = (longint'(1) << 33) / (n + 1);
				if (span > 64'hFFFF_FFFF)
					span = 64'hFFFF_FFFF;
				step_cap = span[31:0];
			end
			default: begin
				cur = VAL_MAX - $urandom_range(0, 40 * n);
				step_cap = 100;
			end
		endcase
		for (int i = 0; i < n; i++) begin
			send_item(bsip_pkg::REQ_WRITE, i[bsip_pkg::INDEX_W-1:0], cur[VALUE_W-1:0]);
			cur = cur + $urandom_range(0, step_cap);
			if (cur > VAL_MAX)
				cur = VAL_MAX;
		end
	endtask

	// Pick a search target: a stored value, a neighbor of one, random, or an extreme
	function automatic logic signed [VALUE_W-1:0] pick_target(input int n_eff);
		int     k;
		int     sv;
		longint v;
		k  = $urandom_range(0, 99);
		sv = $urandom;
		if (n_eff > 0 && k < 50)
			return sb.table_vals[$urandom_range(0, n_eff - 1)];
		if (n_eff > 0 && k < 70) begin
			v = sb.table_vals[$urandom_range(0, n_eff - 1)];
			v = (k % 2 != 0) ? v + 1 : v - 1;
			if (v > VAL_MAX)
				v = VAL_MAX;
			if (v < VAL_MIN)
				v = VAL_MIN;
			return v[VALUE_W-1:0];
		end
		if (k < 90)
			return sv;
		return (k % 2 != 0) ? VAL_MAX[VALUE_W-1:0] : VAL_MIN[VALUE_W-1:0];
	endfunction

	// Result side: check accepted beats; drive ready by a random mode that rx_cycle re-picks
	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready)
			sb.check_result(res_bus.position, res_bus.found);
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: res_bus.ready <= 1'b1;
			1: res_bus.ready <= 1'($urandom_range(0, 1));
			default: begin
				if (stall_left > 0) begin
					res_bus.ready <= 1'b0;
					stall_left--;
				end else begin
					res_bus.ready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 20);
				end
			end
		endcase
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int size_pick;
		int n_eff;
		int searches;
		int phase;
		int sv;
		logic [bsip_pkg::SIZE_W-1:0] size_val;

		sb          = new();
		items_sent  = 0;
		burst_left  = 0;

		arst_n               <= 1'b0;
		cfg_wr_en            <= 1'b0;
		cfg_wr_data          <= '0;
		item_bus.valid       <= 1'b0;
		item_bus.req_type    <= bsip_pkg::REQ_WRITE;
		item_bus.entry_index <= '0;
		item_bus.item_value  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table after reset: any target gives position 0
		send_item(bsip_pkg::REQ_SEARCH, '0, 32'sd0);
		send_item(bsip_pkg::REQ_SEARCH, 10'h3FF, VAL_MAX[VALUE_W-1:0]);

		// Small sorted table with both extremes and a duplicate; touch the last slot
		send_item(bsip_pkg::REQ_WRITE, 10'd0, VAL_MIN[VALUE_W-1:0]);
		send_item(bsip_pkg::REQ_WRITE, 10'd1, -32'sd5);
		send_item(bsip_pkg::REQ_WRITE, 10'd2, 32'sd0);
		send_item(bsip_pkg::REQ_WRITE, 10'd3, 32'sd3);
		send_item(bsip_pkg::REQ_WRITE, 10'd4, 32'sd3);
		send_item(bsip_pkg::REQ_WRITE, 10'd5, 32'sd100);
		send_item(bsip_pkg::REQ_WRITE, 10'd6, VAL_MAX[VALUE_W-1:0]);
		send_item(bsip_pkg::REQ_WRITE, 10'h3FF, -32'sd1);
		drain();
		set_table_size(bsip_pkg::SIZE_W'(7));
		send_item(bsip_pkg::REQ_SEARCH, '0, VAL_MIN[VALUE_W-1:0]);
		send_item(bsip_pkg::REQ_SEARCH, '0, VAL_MAX[VALUE_W-1:0]);
		send_item(bsip_pkg::REQ_SEARCH, '0, 32'sd3);
		send_item(bsip_pkg::REQ_SEARCH, '0, 32'sd1);
		send_item(bsip_pkg::REQ_SEARCH, '0, 32'sd101);
		send_item(bsip_pkg::REQ_SEARCH, '0, -32'sd6);
		send_item(bsip_pkg::REQ_SEARCH, '0, 32'sd2147483646);

		// Single entry table: hit and insert past the end
		drain();
		set_table_size(bsip_pkg::SIZE_W'(1));
		send_item(bsip_pkg::REQ_SEARCH, '0, VAL_MIN[VALUE_W-1:0]);
		send_item(bsip_pkg::REQ_SEARCH, '0, 32'sd0);

		// Random phases: new size, sorted fill (skipped in phase 3), then searches with some stray writes
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			drain();
			if (phase == 2) begin
				size_val = bsip_pkg::SIZE_W'(TABLE_SLOTS);
			end else if (phase == 3) begin
				// oversized: every slot was written in the previous phase
				size_val = '1;
			end else begin
				size_pick = $urandom_range(0, 15);
				if (size_pick == 0)
					size_val = '0;
				else if (size_pick < 3)
					size_val = bsip_pkg::SIZE_W'($urandom_range(33, 120));
				else
					size_val = bsip_pkg::SIZE_W'($urandom_range(1, 32));
			end
			set_table_size(size_val);
			n_eff = (size_val > TABLE_SLOTS) ? TABLE_SLOTS : int'(size_val);
			if (phase != 3)
				fill_sorted(n_eff);
			searches = (phase == 2 || phase == 3) ? 60 : $urandom_range(10, 40);
			for (int s = 0; s < searches; s++) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray write, may break the order
					sv = $urandom;
					send_item(bsip_pkg::REQ_WRITE,
						bsip_pkg::INDEX_W'($urandom_range(0, TABLE_SLOTS - 1)), sv);
				end else begin
					send_item(bsip_pkg::REQ_SEARCH, bsip_pkg::INDEX_W'($urandom),
						pick_target(n_eff));
				end
			end
			phase++;
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
